>>> rtl/core/utrs_pkg.sv
// ----------------------------------------------------------------------------
// utrs_pkg
// Shared types, constants and helper functions for the radix string converter.
// ----------------------------------------------------------------------------
`default_nettype none

package utrs_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int STEP_BITS   = 8;
  localparam int CHUNKS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int PAD_BITS    = CHUNKS * STEP_BITS;
  localparam int MAX_DIGITS  = VALUE_BITS;
  localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
  localparam int SP_W        = $clog2(MAX_DIGITS + 1);
  localparam int S_TDATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((CHAR_W + 7) / 8) * 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_A    = CHAR_W'(65);
  localparam logic [RADIX_W-1:0] DEC_MAX   = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] DEC_BASE  = RADIX_W'(10);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // one queued conversion job
  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [RADIX_W-1:0]     radix;
    logic [CHUNK_IDX_W-1:0] top;
  } job_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] q;
    logic [RADIX_W-1:0]   r;
  } step_t;

  // one chunk of restoring long division by a narrow divisor
  function automatic step_t div_step(input logic [RADIX_W-1:0]   rem_in,
                                     input logic [STEP_BITS-1:0] chunk,
                                     input logic [RADIX_W-1:0]   divisor);
    step_t            res;
    logic [RADIX_W:0] acc;
    res.q = '0;
    acc   = {1'b0, rem_in};
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      acc = {acc[RADIX_W-1:0], chunk[i]};
      if (acc >= {1'b0, divisor}) begin
        acc      = acc - {1'b0, divisor};
        res.q[i] = 1'b1;
      end
    end
    res.r = acc[RADIX_W-1:0];
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DEC_MAX) begin
      c = ASCII_A + CHAR_W'(d - DEC_BASE);
    end else begin
      c = ASCII_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/utrs_front.sv
// ----------------------------------------------------------------------------
// utrs_front
// Input side: holds the radix register and turns each accepted value into a
// job with its radix snapshot and the index of its top significant chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module utrs_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [utrs_pkg::RADIX_W-1:0]    cfg_wdata,
  input  wire logic                            s_tvalid,
  input  wire logic [utrs_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                            q_full,
  output logic                                 s_tready,
  output logic                                 q_push,
  output utrs_pkg::job_t                       q_job
);

  logic [utrs_pkg::RADIX_W-1:0]     radix;
  logic [utrs_pkg::RADIX_W-1:0]     radix_next;
  logic [utrs_pkg::PAD_BITS-1:0]    padded;
  logic [utrs_pkg::CHUNK_IDX_W-1:0] top;

  // saturate the written radix into the legal range
  always_comb begin
    if (cfg_wdata < utrs_pkg::RADIX_MIN) begin
      radix_next = utrs_pkg::RADIX_MIN;
    end else if (cfg_wdata > utrs_pkg::RADIX_MAX) begin
      radix_next = utrs_pkg::RADIX_MAX;
    end else begin
      radix_next = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= utrs_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix <= radix_next;
    end
  end

  // highest non-zero chunk, zero for a zero value
  always_comb begin
    padded = utrs_pkg::PAD_BITS'(s_tdata[utrs_pkg::VALUE_BITS-1:0]);
    top    = '0;
    for (int i = 0; i < utrs_pkg::CHUNKS; i++) begin
      if (padded[i*utrs_pkg::STEP_BITS +: utrs_pkg::STEP_BITS] != '0) begin
        top = utrs_pkg::CHUNK_IDX_W'(i);
      end
    end
  end

  assign s_tready    = !q_full;
  assign q_push      = s_tvalid && !q_full;
  assign q_job.value = s_tdata[utrs_pkg::VALUE_BITS-1:0];
  assign q_job.radix = radix;
  assign q_job.top   = top;

endmodule

`default_nettype wire

>>> rtl/core/utrs_queue.sv
// ----------------------------------------------------------------------------
// utrs_queue
// Two-entry job queue between the input side and the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

module utrs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire utrs_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                valid,
  output utrs_pkg::job_t      head
);

  utrs_pkg::job_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

endmodule

`default_nettype wire

>>> rtl/core/utrs_back.sv
// ----------------------------------------------------------------------------
// utrs_back
// Conversion engine: repeated division by the radix one byte per cycle,
// digits stacked least significant first, then popped out most significant
// first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utrs_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire utrs_pkg::job_t                   q_head,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [utrs_pkg::CHAR_W-1:0]           out_char,
  output logic                                  out_last
);

  utrs_pkg::back_state_t state;
  utrs_pkg::back_state_t state_next;

  logic [utrs_pkg::CHUNKS-1:0][utrs_pkg::STEP_BITS-1:0] val;
  logic [utrs_pkg::RADIX_W-1:0]     radix;
  logic [utrs_pkg::RADIX_W-1:0]     rem;
  logic [utrs_pkg::CHUNK_IDX_W-1:0] chunk_idx;
  logic [utrs_pkg::CHUNK_IDX_W-1:0] qtop;
  logic                             qany;
  logic [utrs_pkg::RADIX_W-1:0]     digits [utrs_pkg::MAX_DIGITS];
  logic [utrs_pkg::SP_W-1:0]        sp;
  logic [utrs_pkg::SP_W-1:0]        sp_dec;
  logic                             out_valid;

  utrs_pkg::step_t step;
  logic            load;
  logic            div;
  logic            emit_go;
  logic            digit_done;
  logic            more;

  assign step       = utrs_pkg::div_step(rem, val[chunk_idx], radix);
  assign digit_done = (chunk_idx == '0);
  assign more       = qany || (step.q != '0);
  assign sp_dec     = sp - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      utrs_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = utrs_pkg::ST_DIV;
        end
      end
      utrs_pkg::ST_DIV: begin
        if (digit_done && !more) begin
          state_next = utrs_pkg::ST_EMIT;
        end
      end
      utrs_pkg::ST_EMIT: begin
        if (emit_go && sp == utrs_pkg::SP_W'(1)) begin
          state_next = utrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = utrs_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    load    = 1'b0;
    div     = 1'b0;
    emit_go = 1'b0;
    case (state)
      utrs_pkg::ST_IDLE: begin
        load = q_valid;
      end
      utrs_pkg::ST_DIV: begin
        div = 1'b1;
      end
      utrs_pkg::ST_EMIT: begin
        emit_go = !out_valid || m_tready;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= utrs_pkg::ST_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (div && digit_done) begin
        sp <= sp + 1'b1;
      end else if (emit_go) begin
        sp <= sp_dec;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val       <= utrs_pkg::PAD_BITS'(q_head.value);
      radix     <= q_head.radix;
      chunk_idx <= q_head.top;
      rem       <= '0;
      qany      <= 1'b0;
    end else if (div) begin
      // quotient overwrites the dividend in place
      val[chunk_idx] <= step.q;
      if (digit_done) begin
        digits[sp[utrs_pkg::DIGIT_IDX_W-1:0]] <= step.r;
        rem  <= '0;
        qany <= 1'b0;
        if (qany) begin
          chunk_idx <= qtop;
        end else begin
          chunk_idx <= '0;
        end
      end else begin
        rem       <= step.r;
        chunk_idx <= chunk_idx - 1'b1;
        if (!qany && step.q != '0) begin
          qtop <= chunk_idx;
          qany <= 1'b1;
        end
      end
    end
    if (emit_go) begin
      out_char <= utrs_pkg::digit_ascii(digits[sp_dec[utrs_pkg::DIGIT_IDX_W-1:0]]);
      out_last <= (sp == utrs_pkg::SP_W'(1));
    end
  end

  assign q_pop    = load;
  assign m_tvalid = out_valid;

endmodule

`default_nettype wire

>>> rtl/core/unsigned_to_radix_string_top.sv
// ----------------------------------------------------------------------------
// unsigned_to_radix_string_top
// Converts 32-bit unsigned values to ASCII text in a configurable radix.
// ----------------------------------------------------------------------------
// Slave stream: s_tdata carries one value per transaction.
// Master stream: one transaction per character, most significant digit first,
// no leading zeros, a zero value gives a single '0'; m_tlast marks the final
// (least significant) character. Digits above nine are upper-case letters.
// cfg_we writes the radix from cfg_wdata; values outside 2..36 saturate.
// Reset sets the radix to ten and empties the job queue and engine.
// Operation: a job is loaded, then each digit takes one pass over the significant
// bytes of the current quotient (one to four) through the single byte-wide
// division step unit; the characters then leave at one per cycle while the
// receiver is ready.
// A two-entry queue lets up to two values wait while a conversion runs.
// When the receiver stalls, the output register holds its character and the
// engine waits; the input side keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_radix_string_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [utrs_pkg::RADIX_W-1:0]    cfg_wdata,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [utrs_pkg::S_TDATA_W-1:0]  s_tdata,   // value
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [utrs_pkg::M_TDATA_W-1:0]       m_tdata,   // digit_char, zero pad
  output logic                                 m_tlast
);

  logic                          q_push;
  logic                          q_pop;
  logic                          q_full;
  logic                          q_valid;
  utrs_pkg::job_t                q_job;
  utrs_pkg::job_t                q_head;
  logic [utrs_pkg::CHAR_W-1:0]   out_char;

  utrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .s_tready  (s_tready),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  utrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  utrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_char (out_char),
    .out_last (m_tlast)
  );

  assign m_tdata = utrs_pkg::M_TDATA_W'(out_char);

endmodule

`default_nettype wire

>>> rtl/core/utrs_checker.sv
// ----------------------------------------------------------------------------
// utrs_checker
// Port-level checks for the radix string converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utrs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [utrs_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic                            m_tlast
);

  logic run_start;

  // high while the next character opens a new string
  always_ff @(posedge clk) begin
    if (rst) begin
      run_start <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      run_start <= m_tlast;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata >= 8'd48 && m_tdata <= 8'd57)
              || (m_tdata >= 8'd65 && m_tdata <= 8'd90))
    else $error("character outside digit set");

  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && run_start && m_tdata == 8'd48 |-> m_tlast)
    else $error("leading zero emitted");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind unsigned_to_radix_string_top utrs_checker u_utrs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/sv/unsigned_to_radix_string_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_to_radix_string_checker
// Watches the value and character streams of the radix string converter,
// spells every accepted value in the radix in force and compares each
// character transaction, and its last flag, against the oldest prediction.
// ----------------------------------------------------------------------------

module unsigned_to_radix_string_checker
  import utrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [RADIX_W-1:0]   cfg_wdata,
  input  wire logic                 s_tvalid,
  input  wire logic                 s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,
  input  wire logic                 m_tvalid,
  input  wire logic                 m_tready,
  input  wire logic [M_TDATA_W-1:0] m_tdata,
  input  wire logic                 m_tlast,
  output int                        fail_count,
  output int                        pending_count,
  output int                        values_seen,
  output int                        chars_seen
);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  char_exp_t          pending_chars[$];
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    values_seen   = 0;
    chars_seen    = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // queue the characters of one value, most significant digit first
  function automatic void spell_value(input logic [VALUE_BITS-1:0] value,
                                      input logic [RADIX_W-1:0]    base);
    logic [RADIX_W-1:0]    digs [MAX_DIGITS];
    logic [VALUE_BITS-1:0] v;
    int                    n;
    char_exp_t             e;
    v = value;
    n = 0;
    do begin
      digs[n] = RADIX_W'(v % base);
      v = v / base;
      n++;
    end while (v != 0);
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] > DEC_MAX) begin
        e.ch = ASCII_A + CHAR_W'(digs[k] - DEC_BASE);
      end else begin
        e.ch = ASCII_ZERO + CHAR_W'(digs[k]);
      end
      e.last = (k == 0);
      pending_chars.push_back(e);
    end
  endfunction

  always @(posedge clk) begin
    char_exp_t want;
    if (rst) begin
      radix_now = RADIX_RESET;
      pending_chars.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_wdata < RADIX_MIN) begin
          radix_now = RADIX_MIN;
        end else if (cfg_wdata > RADIX_MAX) begin
          radix_now = RADIX_MAX;
        end else begin
          radix_now = cfg_wdata;
        end
      end
      // characters first, so an output in the acceptance cycle belongs to older values
      if (m_tvalid && m_tready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("character %h arrived with nothing expected", m_tdata));
        end else begin
          want = pending_chars.pop_front();
          if (m_tdata !== M_TDATA_W'(want.ch)) begin
            report_mismatch($sformatf("char got %h want %h", m_tdata, want.ch));
          end
          if (m_tlast !== want.last) begin
            report_mismatch($sformatf("last flag got %b want %b on char %h",
                                      m_tlast, want.last, want.ch));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        spell_value(s_tdata[VALUE_BITS-1:0], radix_now);
        values_seen++;
      end
    end
    pending_count <= pending_chars.size();
  end

endmodule

>>> tb/sv/unsigned_to_radix_string_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_to_radix_string_top_tb
// Drives values through the radix string converter over a range of radix
// settings, including saturated writes, with random gaps and output stalls;
// the checker beside the block predicts and compares every character.
// ----------------------------------------------------------------------------

module unsigned_to_radix_string_top_tb;
  import utrs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 150;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [RADIX_W-1:0]   cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int   fail_count;
  int   pending_count;
  int   values_seen;
  int   chars_seen;
  int   radix_writes = 0;
  int   cycles       = 0;
  int   stall_left   = 0;
  logic calm         = 1'b0;

  always #10 clk = ~clk;

  unsigned_to_radix_string_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // value
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // digit_char, zero pad
    .m_tlast   (m_tlast)
  );

  unsigned_to_radix_string_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .values_seen   (values_seen),
    .chars_seen    (chars_seen)
  );

  // receiver stalls in bursts, none once calm
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles, pending_count);
      $display("[unsigned_to_radix_string_top] ERROR");
      $finish;
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(v);
    do @(posedge clk); while (!s_tready);
  endtask

  // radix changes only with the converter drained
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_writes++;
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return $urandom >> $urandom_range(1, 31);
      1:       return $urandom_range(0, 40);
      2:       return {VALUE_BITS{1'b1}} >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    case ($urandom_range(0, 3))
      0:       return RADIX_MIN;
      1:       return RADIX_MAX;
      default: return RADIX_W'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // decimal out of reset
    send_value(0);
    send_value(1);
    send_value(9);
    send_value(10);
    send_value(99);
    send_value(1000000000);
    send_value(32'hFFFF_FFFF);
    // zero saturates up to binary
    set_radix(RADIX_W'(0));
    send_value(0);
    send_value(1);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    // all ones saturates down to base thirty-six
    set_radix({RADIX_W{1'b1}});
    send_value(35);
    send_value(36);
    send_value(1295);
    send_value(32'hFFFF_FFFF);
    set_radix(RADIX_W'(16));
    send_value(32'hDEAD_BEEF);
    send_value(15);
    send_value(16);
    set_radix(RADIX_W'(1));
    send_value(5);
    send_value(2);
    set_radix(RADIX_W'(37));
    send_value(0);
    send_value(1296);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        calm = 1'b1;
      end
      set_radix(pick_radix());
      repeat (15) send_value(pick_value());
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("converted %0d values into %0d characters", values_seen, chars_seen);
    $display("radix written %0d times, saturated and edge bases included", radix_writes);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[unsigned_to_radix_string_top] OK");
    end else begin
      $display("[unsigned_to_radix_string_top] ERROR");
    end
    $finish;
  end

endmodule
